@@ rtl/core/dag_source_to_sink_path_count_assert.svh @@
// assertion macros for the source-to-sink path counter
// used by the top level; expects clk and rst in scope
`ifndef DAG_SOURCE_TO_SINK_PATH_COUNT_ASSERT_SVH
`define DAG_SOURCE_TO_SINK_PATH_COUNT_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define DSPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define DSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/dspc_pkg.sv @@
// shared types and constants for the source-to-sink path counter
// no dependencies
package dspc_pkg;
  localparam int MAX_NODES = 4096;
  localparam int MAX_EDGES = 65536;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int LINK_W    = EDGE_W + 1;
  localparam int DEG_W     = EDGE_W + 1;
  localparam int QPTR_W    = NODE_W + 1;
  localparam int SUM_W     = 27;
  localparam logic [SUM_W-1:0]  PATH_MOD   = SUM_W'(80112002);
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_SC_RD,
    ST_SC_CHK,
    ST_Q_CHK,
    ST_Q_DAT,
    ST_N_DAT,
    ST_E_DAT,
    ST_T_UPD,
    ST_S_RD,
    ST_S_ACC
  } state_t;
endpackage

@@ rtl/core/dspc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module dspc_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/dspc_modadd.sv @@
// shared modular adder: (a + b) mod PATH_MOD for operands below the modulus
// depends on dspc_pkg
module dspc_modadd import dspc_pkg::*; (
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  output logic [SUM_W-1:0] y
);
  logic [SUM_W:0] s;

  assign s = {1'b0, a} + {1'b0, b};
  assign y = (s >= {1'b0, PATH_MOD}) ? SUM_W'(s - {1'b0, PATH_MOD}) : s[SUM_W-1:0];
endmodule

@@ rtl/core/dag_source_to_sink_path_count.sv @@
// Source-to-sink path counter for a directed graph.
// Requests carry one edge each (edge_present, src_node, dst_node) and are taken
// when start is high and busy is low. An edge request keeps busy high while
// the edge is linked into the edge store; an empty request without last_edge
// costs nothing. A request with last_edge starts the count: a scan of
// in-degrees, a queue walk over the released nodes and their edges, and a sink
// sum; with node_count zero the count is skipped and the result is zero. The
// result appears on path_count and edge_dropped for one cycle with done high;
// the receiver cannot stall it. Afterwards, and after reset, a clearing pass
// empties the node stores while busy stays high. The count uses one shared
// modular adder and one read port on each store, which sets the walk rate.
// node_count sits at byte address 0 of the APB port; write it only while busy
// is low and no count is under way.
// depends on dspc_pkg, dspc_ram, dspc_modadd and the assertion header
`include "dag_source_to_sink_path_count_assert.svh"
module dag_source_to_sink_path_count import dspc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic              edge_present,
  input  logic [NODE_W-1:0] src_node,
  input  logic [NODE_W-1:0] dst_node,
  input  logic              last_edge,
  output logic              done,
  output logic [SUM_W-1:0]  path_count,
  output logic              edge_dropped
);
  state_t state, state_next;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] idx, clr_idx, src_r, dst_r, nxt_r;
  logic              last_r, dropped;
  logic [QPTR_W-1:0] q_rd, q_wr;
  logic [DEG_W-1:0]  edges_stored;
  logic [SUM_W-1:0]  total, sum_now;
  // link of the edge being applied, held across the update cycle
  logic [LINK_W-1:0] lk_rdata_r;

  // memory ports
  logic              fe_we, deg_we, ho_we, ps_we, q_we, ed_we;
  logic [NODE_W-1:0] fe_waddr, fe_raddr, deg_waddr, deg_raddr, ho_waddr, ho_raddr;
  logic [NODE_W-1:0] ps_waddr, ps_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [LINK_W-1:0] fe_wdata, fe_rdata, lk_rdata;
  logic [DEG_W-1:0]  deg_wdata, deg_rdata, deg_dec;
  logic              ho_wdata, ho_rdata;
  logic [SUM_W-1:0]  ps_wdata, ps_rdata;
  logic [EDGE_W-1:0] ed_waddr, ed_raddr;
  logic [NODE_W-1:0] tg_rdata;

  logic [SUM_W-1:0]  add_a, add_b, add_y;
  logic              accept, in_range, full, q_room;

  dspc_ram #(.AW(NODE_W), .DW(LINK_W)) u_first (.clk, .we(fe_we), .waddr(fe_waddr),
    .wdata(fe_wdata), .raddr(fe_raddr), .rdata(fe_rdata));
  dspc_ram #(.AW(NODE_W), .DW(DEG_W)) u_deg (.clk, .we(deg_we), .waddr(deg_waddr),
    .wdata(deg_wdata), .raddr(deg_raddr), .rdata(deg_rdata));
  dspc_ram #(.AW(NODE_W), .DW(1)) u_hasout (.clk, .we(ho_we), .waddr(ho_waddr),
    .wdata(ho_wdata), .raddr(ho_raddr), .rdata(ho_rdata));
  dspc_ram #(.AW(NODE_W), .DW(SUM_W)) u_sum (.clk, .we(ps_we), .waddr(ps_waddr),
    .wdata(ps_wdata), .raddr(ps_raddr), .rdata(ps_rdata));
  dspc_ram #(.AW(NODE_W), .DW(NODE_W)) u_queue (.clk, .we(q_we), .waddr(q_waddr),
    .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata));
  dspc_ram #(.AW(EDGE_W), .DW(NODE_W)) u_target (.clk, .we(ed_we), .waddr(ed_waddr),
    .wdata(dst_r), .raddr(ed_raddr), .rdata(tg_rdata));
  dspc_ram #(.AW(EDGE_W), .DW(LINK_W)) u_link (.clk, .we(ed_we), .waddr(ed_waddr),
    .wdata(fe_rdata), .raddr(ed_raddr), .rdata(lk_rdata));

  dspc_modadd u_add (.a(add_a), .b(add_b), .y(add_y));

  // apb register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-NODE_W){1'b0}}, node_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_W'(1);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (src_node != '0) && (src_node <= node_count) &&
                    (dst_node != '0) && (dst_node <= node_count);
  assign full     = edges_stored[EDGE_W];
  assign q_room   = !q_wr[NODE_W];
  assign deg_dec  = (deg_rdata != '0) ? deg_rdata - DEG_W'(1) : '0;

  always_comb begin
    state_next = state;
    fe_we = 1'b0; fe_waddr = src_r; fe_wdata = {1'b0, edges_stored[EDGE_W-1:0]};
    fe_raddr = src_r;
    deg_we = 1'b0; deg_waddr = dst_r; deg_wdata = deg_rdata + DEG_W'(1);
    deg_raddr = dst_r;
    ho_we = 1'b0; ho_waddr = src_r; ho_wdata = 1'b1; ho_raddr = idx;
    ps_we = 1'b0; ps_waddr = idx; ps_wdata = SUM_W'(1); ps_raddr = idx;
    q_we = 1'b0; q_waddr = q_wr[NODE_W-1:0]; q_wdata = idx; q_raddr = q_rd[NODE_W-1:0];
    ed_we = 1'b0; ed_waddr = edges_stored[EDGE_W-1:0]; ed_raddr = fe_rdata[EDGE_W-1:0];
    add_a = ps_rdata; add_b = sum_now;
    unique case (state)
      ST_CLEAR: begin
        fe_we = 1'b1; fe_waddr = clr_idx; fe_wdata = EMPTY_LINK;
        deg_we = 1'b1; deg_waddr = clr_idx; deg_wdata = '0;
        ho_we = 1'b1; ho_waddr = clr_idx; ho_wdata = 1'b0;
        ps_we = 1'b1; ps_waddr = clr_idx; ps_wdata = '0;
        if (clr_idx == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (edge_present && in_range && !full) state_next = ST_LD_RD;
          else if (last_edge) state_next = (node_count == '0) ? ST_Q_CHK : ST_SC_RD;
        end
      end
      ST_LD_RD: state_next = ST_LD_WR;
      ST_LD_WR: begin
        fe_we = 1'b1; deg_we = 1'b1; ho_we = 1'b1; ed_we = 1'b1;
        if (last_r) state_next = ST_SC_RD;
        else state_next = ST_IDLE;
      end
      ST_SC_RD: begin
        deg_raddr = idx;
        state_next = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (deg_rdata == '0) begin
          ps_we = 1'b1;
          q_we  = q_room;
        end
        if (idx == node_count) state_next = ST_Q_CHK;
        else state_next = ST_SC_RD;
      end
      ST_Q_CHK: begin
        if (q_rd < q_wr) state_next = ST_Q_DAT;
        else state_next = (node_count == '0) ? ST_CLEAR : ST_S_RD;
      end
      ST_Q_DAT: begin
        fe_raddr = q_rdata;
        ps_raddr = q_rdata;
        state_next = ST_N_DAT;
      end
      ST_N_DAT: begin
        if (fe_rdata[EDGE_W]) state_next = ST_Q_CHK;
        else state_next = ST_E_DAT;
      end
      ST_E_DAT: begin
        deg_raddr = tg_rdata;
        ps_raddr  = tg_rdata;
        state_next = ST_T_UPD;
      end
      ST_T_UPD: begin
        deg_we = 1'b1; deg_waddr = nxt_r; deg_wdata = deg_dec;
        ps_we = 1'b1; ps_waddr = nxt_r; ps_wdata = add_y;
        q_we = (deg_dec == '0) && q_room; q_wdata = nxt_r;
        ed_raddr = lk_rdata_r[EDGE_W-1:0];
        if (lk_rdata_r[EDGE_W]) state_next = ST_Q_CHK;
        else state_next = ST_E_DAT;
      end
      ST_S_RD: state_next = ST_S_ACC;
      ST_S_ACC: begin
        add_a = total; add_b = ps_rdata;
        if (idx == node_count) state_next = ST_CLEAR;
        else state_next = ST_S_RD;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      q_rd         <= '0;
      q_wr         <= '0;
      edges_stored <= '0;
      dropped      <= 1'b0;
      total        <= '0;
      done         <= 1'b0;
      idx          <= NODE_W'(1);
      last_r       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx      <= clr_idx + NODE_W'(1);
          q_rd         <= '0;
          q_wr         <= '0;
          edges_stored <= '0;
          dropped      <= 1'b0;
          total        <= '0;
          idx          <= NODE_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            src_r  <= src_node;
            dst_r  <= dst_node;
            last_r <= last_edge;
            idx    <= NODE_W'(1);
            if (edge_present && !(in_range && !full)) dropped <= 1'b1;
          end
        end
        ST_LD_WR: begin
          edges_stored <= edges_stored + DEG_W'(1);
        end
        ST_SC_CHK: begin
          if (deg_rdata == '0 && q_room) q_wr <= q_wr + QPTR_W'(1);
          if (idx == node_count) idx <= NODE_W'(1);
          else idx <= idx + NODE_W'(1);
        end
        ST_Q_CHK: begin
          if (q_rd < q_wr) begin
            q_rd <= q_rd + QPTR_W'(1);
          end else if (node_count == '0) begin
            path_count   <= '0;
            edge_dropped <= dropped;
            done         <= 1'b1;
            clr_idx      <= '0;
          end
        end
        ST_N_DAT: sum_now <= ps_rdata;
        ST_E_DAT: begin
          nxt_r      <= tg_rdata;
          lk_rdata_r <= lk_rdata;
        end
        ST_T_UPD: begin
          if (deg_dec == '0 && q_room) q_wr <= q_wr + QPTR_W'(1);
        end
        ST_S_ACC: begin
          if (!ho_rdata) total <= add_y;
          if (idx == node_count) begin
            path_count   <= ho_rdata ? total : add_y;
            edge_dropped <= dropped;
            done         <= 1'b1;
            clr_idx      <= '0;
          end else begin
            idx <= idx + NODE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `DSPC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a count")
  `DSPC_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  `DSPC_ASSERT_NOW(a_queue_order, 1'b1, q_rd <= q_wr, "queue read pointer passed write pointer")
  `DSPC_ASSERT_NEXT(a_empty_request, accept && !edge_present && !last_edge, !busy,
    "empty request made the block busy")
endmodule

@@ tb/tb_dag_source_to_sink_path_count.sv @@
// testbench for the source-to-sink path counter: random and directed graphs
// checked against a behavioural path count kept in this file
// depends on dspc_pkg and the rtl top level
module tb_dag_source_to_sink_path_count;
  import dspc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLR_WAIT  = 4400;
  localparam int CYC_LIMIT = 20000000;
  localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct {
    logic              has_edge;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              last;
  } edge_req_t;

  typedef struct {
    logic [SUM_W-1:0] paths;
    logic             dropped;
  } path_res_t;

  logic clk, rst, psel, penable, pwrite, pready, start, busy;
  logic edge_present, last_edge, done, edge_dropped;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic [NODE_W-1:0] src_node, dst_node;
  logic [SUM_W-1:0] path_count;

  dag_source_to_sink_path_count i_dut (.*);

  edge_req_t req_q[$];
  path_res_t want_q[$];
  int unsigned idle_pct = 10;
  int errors = 0;
  longint cycles = 0;

  // graph mirror
  int unsigned nodes_used = 1;
  int unsigned head_of[MAX_NODES];
  int unsigned target_of[MAX_EDGES];
  int unsigned next_of[MAX_EDGES];
  int unsigned indeg[MAX_NODES];
  bit          has_out[MAX_NODES];
  int unsigned psum[MAX_NODES];
  int unsigned n_edges;
  bit          drop_seen;

  function automatic void clear_graph();
    for (int i = 0; i < MAX_NODES; i++) begin
      head_of[i] = MAX_EDGES;
      indeg[i] = 0;
      has_out[i] = 0;
      psum[i] = 0;
    end
    n_edges = 0;
    drop_seen = 0;
  endfunction

  function automatic int unsigned walk_paths();
    int unsigned ready[$];
    int unsigned now, e, nxt, total;
    total = 0;
    for (int unsigned i = 1; i <= nodes_used; i++)
      if (indeg[i] == 0) begin
        psum[i] = 1;
        ready.push_back(i);
      end
    while (ready.size() > 0) begin
      now = ready.pop_front();
      e = head_of[now];
      while (e < MAX_EDGES) begin
        nxt = target_of[e];
        if (indeg[nxt] > 0) indeg[nxt]--;
        psum[nxt] = (psum[nxt] + psum[now]) % 80112002;
        if (indeg[nxt] == 0) ready.push_back(nxt);
        e = next_of[e];
      end
    end
    for (int unsigned i = 1; i <= nodes_used; i++)
      if (!has_out[i]) total = (total + psum[i]) % 80112002;
    return total;
  endfunction

  function automatic void predict_paths(edge_req_t r);
    path_res_t res;
    if (r.has_edge) begin
      if (r.src == 0 || r.src > nodes_used || r.dst == 0 || r.dst > nodes_used ||
          n_edges >= MAX_EDGES) begin
        drop_seen = 1;
      end else begin
        target_of[n_edges] = r.dst;
        next_of[n_edges] = head_of[r.src];
        head_of[r.src] = n_edges;
        n_edges++;
        indeg[r.dst]++;
        has_out[r.src] = 1;
      end
    end
    if (r.last) begin
      res.paths = SUM_W'(walk_paths());
      res.dropped = drop_seen;
      want_q.push_back(res);
      clear_graph();
    end
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    edge_req_t r;
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy)
        predict_paths(edge_req_t'{edge_present, src_node, dst_node, last_edge});
      if (!start || !busy) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = req_q.pop_front();
          edge_present <= r.has_edge;
          src_node <= r.src;
          dst_node <= r.dst;
          last_edge <= r.last;
          start <= 1;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    path_res_t w;
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result paths=%0d dropped=%0b", $time, path_count,
                 edge_dropped);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (path_count !== w.paths) begin
          $display("%0t: path_count expected %0d actual %0d", $time, w.paths, path_count);
          errors++;
        end
        if (edge_dropped !== w.dropped) begin
          $display("%0t: edge_dropped expected %0b actual %0b", $time, w.dropped,
                   edge_dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("[dag_source_to_sink_path_count] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (req_q.size() > 0 || start || want_q.size() > 0) @(posedge clk);
    repeat (CLR_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_NODE_COUNT) nodes_used = data[NODE_W-1:0];
  endtask

  task automatic set_nodes(int unsigned n);
    wait_drained();
    apb_write(ADDR_NODE_COUNT, n);
  endtask

  function automatic void push_req(bit e, int unsigned s, int unsigned d, bit l);
    req_q.push_back(edge_req_t'{e, NODE_W'(s), NODE_W'(d), l});
  endfunction

  // mostly forward edges so most graphs stay acyclic, some noise
  function automatic void random_graph(int unsigned n_items);
    int unsigned s, d, k;
    for (int unsigned i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      s = (nodes_used > 0) ? $urandom_range(nodes_used, 1) : 0;
      d = (nodes_used > 0) ? $urandom_range(nodes_used, 1) : 0;
      if (k < 70 && s > d) begin
        int unsigned t = s;
        s = d;
        d = t;
      end else if (k >= 88 && k < 94) begin
        s = $urandom_range(4095);
      end else if (k >= 94) begin
        d = $urandom_range(4095);
      end
      if ($urandom_range(19) == 0) push_req(0, $urandom_range(4095), $urandom_range(4095), 0);
      if (i == n_items - 1)
        push_req($urandom_range(5) != 0, s, d, 1);
      else
        push_req(1, s, d, 0);
    end
  endfunction

  initial begin
    int unsigned sent, len;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; edge_present = 0; src_node = '0; dst_node = '0; last_edge = 0;
    clear_graph();
    repeat (8) @(posedge clk);
    rst <= 0;

    // reset node count of one, empty graph
    push_req(0, 0, 0, 1);
    set_nodes(0);
    push_req(1, 0, 0, 0);
    push_req(1, 1, 1, 1);
    set_nodes(5);
    push_req(1, 1, 2, 0);
    push_req(1, 1, 3, 0);
    push_req(1, 2, 4, 0);
    push_req(1, 3, 4, 0);
    push_req(1, 4, 5, 0);
    push_req(0, 7, 9, 0);
    push_req(1, 2, 5, 1);
    push_req(1, 3, 3, 0);
    push_req(1, 1, 6, 0);
    push_req(1, 0, 2, 1);
    push_req(1, 1, 2, 0);
    push_req(1, 2, 3, 0);
    push_req(1, 3, 2, 0);
    push_req(1, 4, 5, 1);
    wait_drained();
    apb_write(ADDR_UNUSED, 32'h0000_0007);
    push_req(1, 5, 1, 1);
    set_nodes(4095);
    push_req(0, 0, 0, 1);
    push_req(1, 4095, 1, 0);
    push_req(1, 1, 4095, 0);
    push_req(1, 4095, 4094, 1);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      idle_pct = (ph == 0) ? 10 : (ph == 1) ? 87 : 0;
      sent = 0;
      while (sent < 233) begin
        len = $urandom_range(15, 1);
        if ($urandom_range(9) == 0) begin
          set_nodes($urandom_range(1) ? 4095 : $urandom_range(4095, 2048));
        end else if ($urandom_range(3) == 0) begin
          set_nodes($urandom_range(16));
        end
        random_graph(len);
        sent += len;
      end
    end

    while (req_q.size() > 0 || start || want_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("[dag_source_to_sink_path_count] OK");
    else
      $display("[dag_source_to_sink_path_count] ERROR");
    $finish;
  end
endmodule
